// ===== hdl/rssd_pkg.sv =====
package rssd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PITCH_W = 13;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned CURS_W  = 16;
  localparam int unsigned ROWS_W  = 16;
  localparam int unsigned LIT_W   = 7;
  localparam int unsigned OADDR_W = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;

  localparam logic [PITCH_W-1:0] PITCH_RST = 13'd320;
  localparam logic [BASE_W-1:0]  BASE_RST  = 16'd0;

  localparam logic [CIDX_W-1:0] CFG_LINE_PITCH = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_BASE = 2'd1;

  localparam logic [BYTE_W-1:0] LIT_MAX = 8'h7F;

  localparam logic KIND_LITERAL = 1'b0;
  localparam logic KIND_FILL    = 1'b1;

  typedef enum logic [3:0] {
    PH_ROW_LO = 4'd0,
    PH_ROW_HI = 4'd1,
    PH_CNT_LO = 4'd2,
    PH_CNT_HI = 4'd3,
    PH_SEGS   = 4'd4,
    PH_SKIP   = 4'd5,
    PH_CODE   = 4'd6,
    PH_LIT    = 4'd7,
    PH_FILL   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [OADDR_W-1:0] address;
    logic [BYTE_W-1:0]  length;
    logic [BYTE_W-1:0]  color;
    logic               kind;
  } span_t;

endpackage

// ===== hdl/rle_sprite_span_decoder.sv =====
// Run-length sprite decoder: takes one stream byte per cycle and emits at most
// one pixel span per byte. A byte is accepted every cycle unless a span is
// waiting at the output while the next byte also produces a span; bytes that
// only update header, row or segment state pass even then. A byte goes through
// the input register, then the parse logic, into the output register.
// The start-row multiply (16 x 13) sits in the single parse stage. Write
// line_pitch (index 0) and frame_base (index 1) only while the block is idle.
module rle_sprite_span_decoder #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rssd_pkg::BYTE_W-1:0]   in_stream_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rssd_pkg::OADDR_W-1:0]  out_span_address,
  output logic [rssd_pkg::BYTE_W-1:0]   out_span_length,
  output logic [rssd_pkg::BYTE_W-1:0]   out_span_color,
  output logic                          out_span_kind,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rssd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rssd_pkg::CDATA_W-1:0]  cfg_data
);

  logic [rssd_pkg::PITCH_W-1:0] pitch_r;
  logic [rssd_pkg::BASE_W-1:0]  base_r;

  logic                        hold_valid;
  logic [rssd_pkg::BYTE_W-1:0] hold_byte;
  logic                        take;
  logic                        emits;
  logic                        span_valid;
  logic                        out_free;
  rssd_pkg::span_t             span;
  rssd_pkg::span_t             out_span;

  assign cfg_ready = 1'b1;
  assign take      = hold_valid && (!emits || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= rssd_pkg::PITCH_RST;
      base_r  <= rssd_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rssd_pkg::CFG_LINE_PITCH: pitch_r <= cfg_data[rssd_pkg::PITCH_W-1:0];
        rssd_pkg::CFG_FRAME_BASE: base_r  <= cfg_data[rssd_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  rssd_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_stream_byte(in_stream_byte),
    .take          (take),
    .hold_valid    (hold_valid),
    .hold_byte     (hold_byte)
  );

  rssd_parser #(
    .ADDR_BITS(ADDR_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (take),
    .stream_byte(hold_byte),
    .line_pitch (pitch_r),
    .frame_base (base_r),
    .emits      (emits),
    .span_valid (span_valid),
    .span       (span)
  );

  rssd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (span_valid),
    .span     (span),
    .free     (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_span (out_span)
  );

  assign out_span_address = out_span.address;
  assign out_span_length  = out_span.length;
  assign out_span_color   = out_span.color;
  assign out_span_kind    = out_span.kind;

endmodule

// ===== hdl/rssd_in_reg.sv =====
module rssd_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rssd_pkg::BYTE_W-1:0] in_stream_byte,
  input  logic                       take,
  output logic                       hold_valid,
  output logic [rssd_pkg::BYTE_W-1:0] hold_byte
);

  logic                        valid_r;
  logic [rssd_pkg::BYTE_W-1:0] byte_r;

  assign in_stall   = valid_r && !take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_stream_byte;
    end
  end

endmodule

// ===== hdl/rssd_parser.sv =====
module rssd_parser #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [rssd_pkg::BYTE_W-1:0]   stream_byte,
  input  logic [rssd_pkg::PITCH_W-1:0]  line_pitch,
  input  logic [rssd_pkg::BASE_W-1:0]   frame_base,
  output logic                          emits,
  output logic                          span_valid,
  output rssd_pkg::span_t               span
);

  localparam int unsigned PROD_W = rssd_pkg::ROWS_W + rssd_pkg::PITCH_W;

  rssd_pkg::phase_t phase_r, phase_nxt;
  rssd_pkg::phase_t row_end_ph, seg_end_ph;

  logic [rssd_pkg::BYTE_W-1:0]  low_r, low_nxt;
  logic [ADDR_BITS-1:0]         row_base_r, row_base_nxt;
  logic [rssd_pkg::ROWS_W-1:0]  rows_r, rows_nxt;
  logic [rssd_pkg::BYTE_W-1:0]  segs_r, segs_nxt;
  logic [rssd_pkg::CURS_W-1:0]  cursor_r, cursor_nxt;
  logic [rssd_pkg::LIT_W-1:0]   lits_r, lits_nxt;
  logic [rssd_pkg::BYTE_W-1:0]  fill_r, fill_nxt;

  logic [rssd_pkg::ROWS_W-1:0]  word;
  logic [PROD_W-1:0]            prod;
  logic [ADDR_BITS-1:0]         addr_sum;
  logic                         byte_zero;
  logic                         row_last, seg_last, lit_last;
  logic                         seg_end, row_end;

  assign word      = {stream_byte, low_r};
  assign prod      = PROD_W'(word) * PROD_W'(line_pitch);
  assign byte_zero = (stream_byte == '0);
  assign row_last  = (rows_r == rssd_pkg::ROWS_W'(1));
  assign seg_last  = (segs_r == rssd_pkg::BYTE_W'(1));
  assign lit_last  = (lits_r == rssd_pkg::LIT_W'(1));

  assign row_end_ph = row_last ? rssd_pkg::PH_ROW_LO : rssd_pkg::PH_SEGS;
  assign seg_end_ph = seg_last ? row_end_ph : rssd_pkg::PH_SKIP;

  assign emits = (phase_r == rssd_pkg::PH_LIT) || (phase_r == rssd_pkg::PH_FILL);

  always_comb begin
    seg_end = 1'b0;
    unique case (phase_r)
      rssd_pkg::PH_CODE: seg_end = !stream_byte[rssd_pkg::BYTE_W-1] && byte_zero;
      rssd_pkg::PH_LIT:  seg_end = lit_last;
      rssd_pkg::PH_FILL: seg_end = 1'b1;
      default:           seg_end = 1'b0;
    endcase
    row_end = ((phase_r == rssd_pkg::PH_SEGS) && byte_zero) || (seg_end && seg_last);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        rssd_pkg::PH_ROW_LO: phase_nxt = rssd_pkg::PH_ROW_HI;
        rssd_pkg::PH_ROW_HI: phase_nxt = rssd_pkg::PH_CNT_LO;
        rssd_pkg::PH_CNT_LO: phase_nxt = rssd_pkg::PH_CNT_HI;
        rssd_pkg::PH_CNT_HI: begin
          phase_nxt = (word == '0) ? rssd_pkg::PH_ROW_LO : rssd_pkg::PH_SEGS;
        end
        rssd_pkg::PH_SEGS: begin
          phase_nxt = byte_zero ? row_end_ph : rssd_pkg::PH_SKIP;
        end
        rssd_pkg::PH_SKIP: phase_nxt = rssd_pkg::PH_CODE;
        rssd_pkg::PH_CODE: begin
          if (stream_byte > rssd_pkg::LIT_MAX) begin
            phase_nxt = rssd_pkg::PH_FILL;
          end else begin
            phase_nxt = byte_zero ? seg_end_ph : rssd_pkg::PH_LIT;
          end
        end
        rssd_pkg::PH_LIT:  phase_nxt = lit_last ? seg_end_ph : rssd_pkg::PH_LIT;
        rssd_pkg::PH_FILL: phase_nxt = seg_end_ph;
        default:           phase_nxt = rssd_pkg::PH_ROW_HI;
      endcase
    end
  end

  // counters and span
  always_comb begin
    low_nxt      = low_r;
    row_base_nxt = row_base_r;
    rows_nxt     = rows_r;
    segs_nxt     = segs_r;
    cursor_nxt   = cursor_r;
    lits_nxt     = lits_r;
    fill_nxt     = fill_r;

    addr_sum = row_base_r + ADDR_BITS'(frame_base) + ADDR_BITS'(cursor_r);

    span.address = addr_sum[rssd_pkg::OADDR_W-1:0];
    span.color   = stream_byte;
    span.length  = (phase_r == rssd_pkg::PH_FILL) ? fill_r : rssd_pkg::BYTE_W'(1);
    span.kind    = (phase_r == rssd_pkg::PH_FILL) ? rssd_pkg::KIND_FILL
                                                  : rssd_pkg::KIND_LITERAL;
    span_valid   = fire && emits;

    if (fire) begin
      unique case (phase_r)
        rssd_pkg::PH_ROW_HI: row_base_nxt = prod[ADDR_BITS-1:0];
        rssd_pkg::PH_CNT_LO: low_nxt = stream_byte;
        rssd_pkg::PH_CNT_HI: rows_nxt = word;
        rssd_pkg::PH_SEGS: begin
          cursor_nxt = '0;
          segs_nxt   = stream_byte;
        end
        rssd_pkg::PH_SKIP: begin
          cursor_nxt = cursor_r + rssd_pkg::CURS_W'(stream_byte);
        end
        rssd_pkg::PH_CODE: begin
          if (stream_byte > rssd_pkg::LIT_MAX) begin
            fill_nxt = rssd_pkg::BYTE_W'(9'd256 - {1'b0, stream_byte});
          end else begin
            lits_nxt = stream_byte[rssd_pkg::LIT_W-1:0];
          end
        end
        rssd_pkg::PH_LIT: begin
          cursor_nxt = cursor_r + rssd_pkg::CURS_W'(1);
          lits_nxt   = lits_r - rssd_pkg::LIT_W'(1);
        end
        rssd_pkg::PH_FILL: begin
          cursor_nxt = cursor_r + rssd_pkg::CURS_W'(fill_r);
        end
        default: low_nxt = stream_byte;
      endcase

      if (seg_end) begin
        segs_nxt = segs_r - rssd_pkg::BYTE_W'(1);
      end
      if (row_end) begin
        row_base_nxt = row_base_r + ADDR_BITS'(line_pitch);
        rows_nxt     = rows_r - rssd_pkg::ROWS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rssd_pkg::PH_ROW_LO;
      low_r      <= '0;
      row_base_r <= '0;
      rows_r     <= '0;
      segs_r     <= '0;
      cursor_r   <= '0;
      lits_r     <= '0;
      fill_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      low_r      <= low_nxt;
      row_base_r <= row_base_nxt;
      rows_r     <= rows_nxt;
      segs_r     <= segs_nxt;
      cursor_r   <= cursor_nxt;
      lits_r     <= lits_nxt;
      fill_r     <= fill_nxt;
    end
  end

endmodule

// ===== hdl/rssd_out_reg.sv =====
module rssd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  rssd_pkg::span_t span,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output rssd_pkg::span_t out_span
);

  logic            valid_r, valid_nxt;
  rssd_pkg::span_t span_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_span  = span_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      span_r <= span;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RUN_LIMIT     = 1000000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_BYTES   = 150;

  localparam logic [rssd_pkg::CIDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [rssd_pkg::CIDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam rssd_pkg::span_t NO_SPAN = '0;

  typedef struct {
    logic [rssd_pkg::BYTE_W-1:0] data;
    bit                          typed;
    rssd_pkg::span_t             want;
  } vec_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [rssd_pkg::BYTE_W-1:0]   in_stream_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [rssd_pkg::OADDR_W-1:0]  out_span_address;
  logic [rssd_pkg::BYTE_W-1:0]   out_span_length;
  logic [rssd_pkg::BYTE_W-1:0]   out_span_color;
  logic                          out_span_kind;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rssd_pkg::CIDX_W-1:0]   cfg_index;
  logic [rssd_pkg::CDATA_W-1:0]  cfg_data;

  rle_sprite_span_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_address (out_span_address),
    .out_span_length  (out_span_length),
    .out_span_color   (out_span_color),
    .out_span_kind    (out_span_kind),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // decoder state mirror
  logic [rssd_pkg::PITCH_W-1:0] pitch_q;
  logic [rssd_pkg::BASE_W-1:0]  base_q;
  rssd_pkg::phase_t             dec_phase;
  logic [rssd_pkg::BYTE_W-1:0]  hold_lo;
  logic [15:0]                  row_base_q;
  logic [rssd_pkg::ROWS_W-1:0]  rows_left;
  logic [rssd_pkg::BYTE_W-1:0]  segs_left;
  logic [rssd_pkg::CURS_W-1:0]  cur_x;
  logic [rssd_pkg::LIT_W-1:0]   lits_left;
  logic [rssd_pkg::BYTE_W-1:0]  fill_len;

  rssd_pkg::span_t pending_spans[$];
  int unsigned     fail_count;
  int unsigned     phase_sent;
  bit              calm;
  bit              rx_hold_req;
  bit              cut_on;
  int unsigned     cut_at;
  int unsigned     sprite_pos;

  vec_t dir_vec [0:26] = '{
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h02, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, NO_SPAN},
    '{8'h00, 1'b1, '{16'h0000, 8'd1, 8'h00, rssd_pkg::KIND_LITERAL}},
    '{8'hFF, 1'b0, NO_SPAN},
    '{8'h80, 1'b0, NO_SPAN},
    '{8'hFF, 1'b1, '{16'h0100, 8'd128, 8'hFF, rssd_pkg::KIND_FILL}},
    '{8'hFF, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h02, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, NO_SPAN},
    '{8'h03, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, NO_SPAN},
    '{8'h10, 1'b0, NO_SPAN},
    '{8'h00, 1'b0, NO_SPAN},
    '{8'h01, 1'b0, NO_SPAN},
    '{8'h7F, 1'b0, NO_SPAN},
    '{8'hFF, 1'b0, NO_SPAN},
    '{8'h5A, 1'b0, NO_SPAN}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void close_row();
    row_base_q = row_base_q + 16'(pitch_q);
    rows_left  = rows_left - rssd_pkg::ROWS_W'(1);
    dec_phase  = (rows_left == 0) ? rssd_pkg::PH_ROW_LO : rssd_pkg::PH_SEGS;
  endfunction

  function automatic void close_segment();
    segs_left = segs_left - rssd_pkg::BYTE_W'(1);
    if (segs_left == 0) close_row();
    else dec_phase = rssd_pkg::PH_SKIP;
  endfunction

  task automatic decode_byte(input logic [rssd_pkg::BYTE_W-1:0] b, output bit made,
                             output rssd_pkg::span_t sp);
    logic [31:0] prod;
    made = 1'b0;
    sp   = NO_SPAN;
    sp.address = base_q + row_base_q + cur_x;
    sp.color   = b;
    case (dec_phase)
      rssd_pkg::PH_ROW_HI: begin
        prod       = {16'd0, b, hold_lo} * {19'd0, pitch_q};
        row_base_q = prod[15:0];
        dec_phase  = rssd_pkg::PH_CNT_LO;
      end
      rssd_pkg::PH_CNT_LO: begin
        hold_lo   = b;
        dec_phase = rssd_pkg::PH_CNT_HI;
      end
      rssd_pkg::PH_CNT_HI: begin
        rows_left = {b, hold_lo};
        dec_phase = (rows_left == 0) ? rssd_pkg::PH_ROW_LO : rssd_pkg::PH_SEGS;
      end
      rssd_pkg::PH_SEGS: begin
        cur_x     = '0;
        segs_left = b;
        if (b == 0) close_row();
        else dec_phase = rssd_pkg::PH_SKIP;
      end
      rssd_pkg::PH_SKIP: begin
        cur_x     = cur_x + 16'(b);
        dec_phase = rssd_pkg::PH_CODE;
      end
      rssd_pkg::PH_CODE: begin
        if (b <= rssd_pkg::LIT_MAX) begin
          lits_left = b[rssd_pkg::LIT_W-1:0];
          if (b == 0) close_segment();
          else dec_phase = rssd_pkg::PH_LIT;
        end else begin
          fill_len  = 8'(9'd256 - {1'b0, b});
          dec_phase = rssd_pkg::PH_FILL;
        end
      end
      rssd_pkg::PH_LIT: begin
        made      = 1'b1;
        sp.length = 8'd1;
        sp.kind   = rssd_pkg::KIND_LITERAL;
        cur_x     = cur_x + rssd_pkg::CURS_W'(1);
        lits_left = lits_left - rssd_pkg::LIT_W'(1);
        if (lits_left == 0) close_segment();
      end
      rssd_pkg::PH_FILL: begin
        made      = 1'b1;
        sp.length = fill_len;
        sp.kind   = rssd_pkg::KIND_FILL;
        cur_x     = cur_x + 16'(fill_len);
        close_segment();
      end
      default: begin
        hold_lo   = b;
        dec_phase = rssd_pkg::PH_ROW_HI;
      end
    endcase
  endtask

  // called and returns at a falling edge
  task automatic send_byte(input logic [rssd_pkg::BYTE_W-1:0] b, input bit typed,
                           input rssd_pkg::span_t want);
    int unsigned     gap;
    int unsigned     r;
    bit              made;
    rssd_pkg::span_t sp;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, made, sp);
    if (typed) pending_spans.push_back(want);
    else if (made) pending_spans.push_back(sp);
    phase_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic [rssd_pkg::BYTE_W-1:0] b);
    sprite_pos++;
    if (cut_on && sprite_pos > cut_at) return;
    send_byte(b, 1'b0, NO_SPAN);
  endtask

  task automatic send_sprite(input bit broken, input bit tall);
    logic [15:0]                 start;
    logic [15:0]                 nrows;
    logic [rssd_pkg::BYTE_W-1:0] b;
    int unsigned                 nsegs;
    int unsigned                 nlit;
    int unsigned                 r;
    sprite_pos = 0;
    cut_on     = broken;
    cut_at     = $urandom_range(4, 30);
    start      = 16'($urandom);
    r          = $urandom_range(0, 99);
    if (tall) nrows = 16'($urandom_range(256, 259));
    else if (r < 5) nrows = '0;
    else nrows = 16'($urandom_range(1, 4));
    put(start[7:0]);
    put(start[15:8]);
    put(nrows[7:0]);
    put(nrows[15:8]);
    for (int row = 0; row < nrows; row++) begin
      if (tall) nsegs = ($urandom_range(0, 9) == 0) ? 1 : 0;
      else nsegs = $urandom_range(0, 4);
      put(8'(nsegs));
      repeat (nsegs) begin
        put(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 19) == 0) nlit = $urandom_range(64, rssd_pkg::LIT_MAX);
          else nlit = $urandom_range(1, 6);
          put(8'(nlit));
          repeat (nlit) put(8'($urandom));
        end else if (r < 90) begin
          put(8'($urandom_range(rssd_pkg::LIT_MAX + 1, 255)));
          put(8'($urandom));
        end else begin
          put(8'h00);
        end
      end
    end
    if (broken) begin
      // truncated sprite plus one stray byte, then steer back to a header
      cut_on = 1'b0;
      send_byte(8'($urandom), 1'b0, NO_SPAN);
      while (dec_phase != rssd_pkg::PH_ROW_LO) begin
        case (dec_phase)
          rssd_pkg::PH_CNT_LO, rssd_pkg::PH_CNT_HI,
          rssd_pkg::PH_SEGS, rssd_pkg::PH_CODE: b = 8'h00;
          default: b = 8'($urandom);
        endcase
        send_byte(b, 1'b0, NO_SPAN);
      end
    end
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [rssd_pkg::CIDX_W-1:0] idx,
                           input logic [rssd_pkg::CDATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rssd_pkg::CFG_LINE_PITCH) pitch_q = value[rssd_pkg::PITCH_W-1:0];
    else if (idx == rssd_pkg::CFG_FRAME_BASE) base_q = value[rssd_pkg::BASE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : receiver_pacing
    int unsigned busy_left;
    int unsigned free_left;
    int unsigned hold_left;
    int unsigned r;
    busy_left = 0;
    free_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (busy_left != 0) begin
        busy_left--;
        out_stall <= 1'b1;
      end else if (free_left != 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          free_left = $urandom_range(0, 7);
          out_stall <= 1'b0;
        end else if (r < 96) begin
          busy_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          busy_left = $urandom_range(20, 80);
          out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : span_check
    rssd_pkg::span_t got;
    rssd_pkg::span_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_span_address, out_span_length, out_span_color, out_span_kind};
      if (pending_spans.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected span addr %h len %0d color %h kind %0b",
                 $time, got.address, got.length, got.color, got.kind);
      end else begin
        want = pending_spans.pop_front();
        if (got !== want) begin
          fail_count++;
          $display({"%0t: span mismatch: expected addr %h len %0d color %h kind %0b,",
                    " got addr %h len %0d color %h kind %0b"},
                   $time, want.address, want.length, want.color, want.kind,
                   got.address, got.length, got.color, got.kind);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout", $time);
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    int unsigned n;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_stream_byte <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= rssd_pkg::CFG_LINE_PITCH;
    cfg_data       <= '0;
    fail_count  = 0;
    phase_sent  = 0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    cut_on      = 1'b0;
    cut_at      = 0;
    sprite_pos  = 0;
    pitch_q     = rssd_pkg::PITCH_RST;
    base_q      = rssd_pkg::BASE_RST;
    dec_phase   = rssd_pkg::PH_ROW_LO;
    hold_lo     = '0;
    row_base_q  = '0;
    rows_left   = '0;
    segs_left   = '0;
    cur_x       = '0;
    lits_left   = '0;
    fill_len    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < $size(dir_vec); i++)
      send_byte(dir_vec[i].data, dir_vec[i].typed, dir_vec[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          cfg_write(rssd_pkg::CFG_LINE_PITCH, 16'd1);
          cfg_write(rssd_pkg::CFG_FRAME_BASE, 16'hFFFF);
        end
        2: begin
          calm = 1'b1;
          cfg_write(rssd_pkg::CFG_LINE_PITCH, 16'd0);
          cfg_write(rssd_pkg::CFG_FRAME_BASE, 16'h0000);
        end
        3: begin
          calm = 1'b0;
          cfg_write(rssd_pkg::CFG_LINE_PITCH, 16'hFFFF);
          cfg_write(rssd_pkg::CFG_FRAME_BASE, 16'h8000);
          cfg_write(CFG_SPARE_LO, 16'($urandom));
          cfg_write(CFG_SPARE_HI, 16'($urandom));
        end
        4: begin
          cfg_write(rssd_pkg::CFG_LINE_PITCH, 16'd4096);
          cfg_write(rssd_pkg::CFG_FRAME_BASE, 16'($urandom));
          rx_hold_req = 1'b1;
        end
        5: begin
          cfg_write(rssd_pkg::CFG_LINE_PITCH, 16'($urandom_range(1, 4096)));
          cfg_write(rssd_pkg::CFG_FRAME_BASE, 16'($urandom));
        end
        default: ;
      endcase
      phase_sent = 0;
      n = 0;
      while (phase_sent < PHASE_BYTES) begin
        send_sprite($urandom_range(0, 9) == 0, (ph == 1 || ph == 4) && n == 0);
        n++;
      end
      wait_idle();
    end

    if (pending_spans.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected spans never arrived", $time, pending_spans.size());
    end
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
